/* hw/rtl/tcw_pkg.sv */
// Shared types, command codes and character constants of the text console writer.
package tcw_pkg;

  // Command codes carried in the command field of an input word.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_NULL    = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Configuration register indexes.
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam int CFG_DATA_W = 7;

  // Screen size after reset, before any limit by the store size.
  localparam int RESET_COLUMNS = 80;
  localparam int RESET_ROWS    = 25;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] character;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_value;
    logic       scrolled;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCR_COPY,
    ST_SCR_DRAIN,
    ST_SCR_FILL,
    ST_DONE
  } tcw_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic put_char;
    logic new_line;
    logic home;
    logic read_issue;
    logic clr_start;
    logic clr_step;
    logic scr_start;
    logic copy_step;
    logic fill_step;
    logic out_load;
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       is_newline;
    logic       is_null;
    logic       wrap;
    logic       last_row;
    logic       single_row;
    logic       clr_last;
    logic       copy_last;
    logic       fill_last;
    logic       out_free;
  } tcw_sts_t;

endpackage

/* hw/rtl/text_console_writer.sv */
// Top level of the text console writer: controller, datapath and port assertions.
//
// A text-mode console with a screen store of MAX_ROWS x MAX_COLUMNS characters and
// a cursor. Each input word carries a command: put one character (newline moves to
// the next row, tab is stored as a space, zero is ignored), clear the screen, or read
// one cell. Every input word yields exactly one result word with the cursor position
// after the command, the cell read (zero otherwise) and a flag that is set when the
// command scrolled the screen up by one row.
// A put that scrolls walks the rows through the store's write and read ports; a clear writes
// every cell of the store with a space, one cell written per cycle.
// One word is worked on at a time, so no new word is taken while one is in flight. A result
// held back by out_stall does not block the next word; a word whose result finds the
// result register still occupied waits for it before the block takes more.
// After reset a clearing pass fills the whole store with spaces; in_stall stays high
// until it is done. The user must write the size registers over the cfg port only while
// no word is in flight; the block itself does not enforce this. Each write homes the
// cursor and leaves the store untouched.
module text_console_writer #(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tcw_pkg::tcw_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tcw_pkg::tcw_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;
  logic     cfg_we;

  // The size registers are plain flops, so a write is always taken.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // A result is never loaded over one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register loaded while a result was still held");

  // An accepted word keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after an accepted word");

  // At most one store operation (put, clear, fill or copy) is issued in any cycle.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.put_char, cmd.clr_step, cmd.fill_step, cmd.copy_step}))
    else $error("two store operations issued in one cycle");

  // Reset starts the clearing pass, during which no input is taken.
  a_init_pass: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input accepted before the clearing pass after reset");

endmodule

/* hw/rtl/tcw_ctrl.sv */
// Controller state machine of the text console writer.
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  tcw_state_t state_r;
  tcw_state_t state_nxt;
  logic       finish;
  logic       scroll;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    finish    = 1'b0;
    scroll    = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.command)
          CMD_PUT: begin
            if (sts.is_null) begin
              finish = 1'b1;
            end else if (sts.is_newline) begin
              cmd.new_line = 1'b1;
              scroll       = sts.last_row;
              finish       = !sts.last_row;
            end else begin
              cmd.put_char = 1'b1;
              cmd.new_line = sts.wrap;
              scroll       = sts.wrap && sts.last_row;
              finish       = !(sts.wrap && sts.last_row);
            end
          end
          CMD_CLEAR: begin
            cmd.home      = 1'b1;
            cmd.clr_start = 1'b1;
            state_nxt     = ST_CLEAR;
          end
          CMD_READ: begin
            cmd.read_issue = 1'b1;
            state_nxt      = ST_DONE;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (scroll) begin
          cmd.scr_start = 1'b1;
          state_nxt     = sts.single_row ? ST_SCR_FILL : ST_SCR_COPY;
        end else if (finish) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCR_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) begin
          state_nxt = ST_SCR_DRAIN;
        end
      end
      ST_SCR_DRAIN: begin
        // The last copied cell is written back in this cycle.
        state_nxt = ST_SCR_FILL;
      end
      ST_SCR_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

endmodule

/* hw/rtl/tcw_datapath.sv */
// Datapath of the text console writer: screen store, cursor, size registers and result register.
module tcw_datapath #(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tcw_pkg::tcw_in_t                in_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            out_stall,
  output logic                            out_valid,
  output tcw_pkg::tcw_out_t               out_data,
  input  tcw_pkg::tcw_cmd_t               cmd,
  output tcw_pkg::tcw_sts_t               sts
);
  import tcw_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [6:0] COLS_MAX = 7'((MAX_COLUMNS > 127) ? 127 : MAX_COLUMNS);
  localparam logic [4:0] ROWS_MAX = 5'((MAX_ROWS > 31) ? 31 : MAX_ROWS);
  localparam logic [6:0] COLS_RST =
    7'((int'(COLS_MAX) < RESET_COLUMNS) ? int'(COLS_MAX) : RESET_COLUMNS);
  localparam logic [4:0] ROWS_RST =
    5'((int'(ROWS_MAX) < RESET_ROWS) ? int'(ROWS_MAX) : RESET_ROWS);

  function automatic logic [AW-1:0] cell_addr(logic [4:0] row, logic [6:0] col);
    return AW'(int'(row) * MAX_COLUMNS + int'(col));
  endfunction

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;

  tcw_in_t       item_r;
  logic [6:0]    cols_r;
  logic [4:0]    rows_r;
  logic [6:0]    col_r, col_nxt;
  logic [4:0]    row_r, row_nxt;
  logic          scrolled_r, scrolled_nxt;
  logic          read_ok_r;
  logic          read_ok;
  logic [AW-1:0] sweep_r;
  logic [6:0]    sc_r;
  logic [4:0]    sr_r;
  logic          pend_r;
  logic [AW-1:0] dst_r;
  logic          out_valid_r;
  tcw_out_t      out_data_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    char_w;
  logic [6:0]    cfg_cols;
  logic [4:0]    cfg_rows;
  logic          row_end;

  // Size registers: zero counts as one, a size above the store is limited; rows use bits 4:0.
  always_comb begin
    if (cfg_data == 7'd0) begin
      cfg_cols = 7'd1;
    end else if (cfg_data > COLS_MAX) begin
      cfg_cols = COLS_MAX;
    end else begin
      cfg_cols = cfg_data;
    end
    if (cfg_data[4:0] == 5'd0) begin
      cfg_rows = 5'd1;
    end else if (cfg_data[4:0] > ROWS_MAX) begin
      cfg_rows = ROWS_MAX;
    end else begin
      cfg_rows = cfg_data[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RST;
      rows_r <= ROWS_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_COLUMNS) begin
        cols_r <= cfg_cols;
      end else begin
        rows_r <= cfg_rows;
      end
    end
  end

  assign char_w  = (item_r.character == CH_TAB) ? CH_SPACE : item_r.character;
  assign read_ok = (item_r.read_row < rows_r) && (item_r.read_col < cols_r);
  assign row_end = (sc_r == cols_r - 7'd1);

  // Cursor update.
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    scrolled_nxt = scrolled_r;
    if (cmd.latch) begin
      scrolled_nxt = 1'b0;
    end
    priority if (cfg_we || cmd.home) begin
      col_nxt = 7'd0;
      row_nxt = 5'd0;
    end else if (cmd.new_line) begin
      col_nxt = 7'd0;
      if (sts.last_row) begin
        row_nxt      = rows_r - 5'd1;
        scrolled_nxt = 1'b1;
      end else begin
        row_nxt = row_r + 5'd1;
      end
    end else if (cmd.put_char) begin
      col_nxt = col_r + 7'd1;
    end else begin
      col_nxt = col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= 7'd0;
      row_r      <= 5'd0;
      scrolled_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      scrolled_r <= scrolled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_ok_r <= 1'b0;
    end else if (cmd.latch) begin
      read_ok_r <= 1'b0;
    end else if (cmd.read_issue) begin
      read_ok_r <= read_ok;
    end
  end

  // Sweep counters for clearing and scrolling.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      sc_r    <= 7'd0;
      sr_r    <= 5'd0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= cmd.copy_step;
      if (cmd.clr_start) begin
        sweep_r <= '0;
      end else if (cmd.clr_step) begin
        sweep_r <= sweep_r + AW'(1);
      end
      if (cmd.scr_start) begin
        sc_r <= 7'd0;
        sr_r <= 5'd0;
      end else if (cmd.copy_step) begin
        if (row_end) begin
          sc_r <= 7'd0;
          sr_r <= sr_r + 5'd1;
        end else begin
          sc_r <= sc_r + 7'd1;
        end
      end else if (cmd.fill_step) begin
        sc_r <= sc_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_step) begin
      dst_r <= cell_addr(sr_r, sc_r);
    end
  end

  // Store ports: one write, one registered read.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cell_addr(row_r, col_r);
    wr_data = char_w;
    priority if (pend_r) begin
      wr_en   = 1'b1;
      wr_addr = dst_r;
      wr_data = rdata_r;
    end else if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
      wr_data = CH_SPACE;
    end else if (cmd.fill_step) begin
      wr_en   = 1'b1;
      wr_addr = cell_addr(rows_r - 5'd1, sc_r);
      wr_data = CH_SPACE;
    end else if (cmd.put_char) begin
      wr_en = 1'b1;
    end else begin
      wr_en = 1'b0;
    end
  end

  assign rd_en   = cmd.copy_step || (cmd.read_issue && read_ok);
  assign rd_addr = cmd.copy_step ? cell_addr(sr_r + 5'd1, sc_r)
                                 : cell_addr(item_r.read_row, item_r.read_col);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.cursor_col <= col_nxt;
      out_data_r.cursor_row <= row_nxt;
      out_data_r.cell_value <= read_ok_r ? rdata_r : CH_NULL;
      out_data_r.scrolled   <= scrolled_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts            = '0;
    sts.command    = item_r.command;
    sts.is_newline = (item_r.character == CH_NEWLINE);
    sts.is_null    = (item_r.character == CH_NULL);
    sts.wrap       = ({1'b0, col_r} + 8'd1) >= {1'b0, cols_r};
    sts.last_row   = ({1'b0, row_r} + 6'd1) >= {1'b0, rows_r};
    sts.single_row = (rows_r == 5'd1);
    sts.clr_last   = (sweep_r == AW'(DEPTH - 1));
    sts.copy_last  = row_end && ((sr_r + 5'd1) == (rows_r - 5'd1));
    sts.fill_last  = row_end;
    sts.out_free   = !out_valid_r || !out_stall;
  end

endmodule
